// ----- hw/rtl/lfpd_pkg.sv -----
`default_nettype none
package lfpd_pkg;

	localparam int SENSOR_COUNT = 6;
	localparam int SAMPLE_W     = 8;
	localparam int ERR_W        = 4;
	localparam int PAT_W        = SENSOR_COUNT;
	localparam int CFG_IDX_W    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

	localparam logic [SAMPLE_W-1:0] BASE_SPEED_RST = 8'd130;
	localparam logic [SAMPLE_W-1:0] GAIN_PROP_RST  = 8'd20;
	localparam logic [SAMPLE_W-1:0] GAIN_DERIV_RST = 8'd5;
	localparam logic [SAMPLE_W-1:0] MIN_SEEN_RST   = 8'd255;
	localparam logic [SAMPLE_W-1:0] MAX_SEEN_RST   = 8'd0;
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 8'd128;
	localparam logic [SAMPLE_W-1:0] DUTY_MAX       = 8'd255;

	// action codes
	localparam logic ACT_CALIBRATE = 1'b0;
	localparam logic ACT_STEER     = 1'b1;

	// sensor patterns, sensor 0 in the MSB, 1 = white
	localparam logic [PAT_W-1:0] PAT_CENTER    = 6'b110011;
	localparam logic [PAT_W-1:0] PAT_LEFT_3    = 6'b111110;
	localparam logic [PAT_W-1:0] PAT_LEFT_2    = 6'b111001;
	localparam logic [PAT_W-1:0] PAT_LEFT_1    = 6'b111011;
	localparam logic [PAT_W-1:0] PAT_RIGHT_1   = 6'b110111;
	localparam logic [PAT_W-1:0] PAT_RIGHT_2   = 6'b011111;
	localparam logic [PAT_W-1:0] PAT_RIGHT_3   = 6'b100111;
	localparam logic [PAT_W-1:0] PAT_ALL_WHITE = 6'b111111;

	typedef struct packed {
		logic                action;
		logic [SAMPLE_W-1:0] sample_0;
		logic [SAMPLE_W-1:0] sample_1;
		logic [SAMPLE_W-1:0] sample_2;
		logic [SAMPLE_W-1:0] sample_3;
		logic [SAMPLE_W-1:0] sample_4;
		logic [SAMPLE_W-1:0] sample_5;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]     left_duty;
		logic [SAMPLE_W-1:0]     right_duty;
		logic signed [ERR_W-1:0] position_error;
		logic [PAT_W-1:0]        sensor_pattern;
		logic [SAMPLE_W-1:0]     threshold_now;
	} result_t;

	// per-sensor lane findings
	typedef struct packed {
		logic                above;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
	} lane_t;

	// merged view of one item, toward the drive pipeline
	typedef struct packed {
		logic [PAT_W-1:0]          pattern;
		logic signed [ERR_W-1:0]   err;
		logic signed [ERR_W:0]     diff;
		logic [SAMPLE_W-1:0]       min_next;
		logic [SAMPLE_W-1:0]       max_next;
		logic [SAMPLE_W-1:0]       thr_cal;
	} status_t;

	function automatic logic signed [ERR_W-1:0] map_error(
		input logic [PAT_W-1:0]        pat,
		input logic signed [ERR_W-1:0] prev
	);
		logic signed [ERR_W-1:0] e;
		case (pat)
			PAT_CENTER:  e = 4'sd0;
			PAT_LEFT_3:  e = -4'sd3;
			PAT_LEFT_2:  e = -4'sd2;
			PAT_LEFT_1:  e = -4'sd1;
			PAT_RIGHT_1: e = 4'sd1;
			PAT_RIGHT_2: e = 4'sd2;
			PAT_RIGHT_3: e = 4'sd3;
			PAT_ALL_WHITE: begin
				// line lost: push hard toward the side it was last seen
				if (prev < 4'sd0)
					e = -4'sd4;
				else if (prev > 4'sd0)
					e = 4'sd4;
				else
					e = 4'sd0;
			end
			default: e = prev;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/line_follower_pd_steering_unit.sv -----
// Line follower PD steering unit.
//
// item channel: one transfer carries an action bit and six 8-bit sensor samples.
//   A calibrate item folds the samples into the running min/max and moves the
//   threshold to their midpoint; a steer item thresholds the samples, maps the
//   pattern to a position error and drives the two wheel duties.
// result channel: exactly one result per item, in order.
// cfg channel: index 0 base speed, 1 proportional gain, 2 derivative gain;
//   other indexes are dropped. Always ready; write only while the unit is idle.
// Pipeline: an item passes the stage 1, stage 2 and result registers before
//   result_valid rises. Throughput: one item per cycle unless the result side
//   stalls; calibration state, threshold and last error are all updated in
//   the first stage, so the next item sees them with no gap.
// Reset: gains and base speed go to 20/5/130, threshold to 128, min/max to
//   255/0, last error to 0; the pipeline empties.
// Stall: while result_valid is high and result_ready low the whole pipeline
//   holds and item_ready drops; up to three items sit inside.
`default_nettype none
module line_follower_pd_steering_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire lfpd_pkg::item_t                   item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output lfpd_pkg::result_t                      result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lfpd_pkg::SAMPLE_W-1:0]     cfg_data
);
	import lfpd_pkg::*;

	logic [SAMPLE_W-1:0]     base_speed_q;
	logic [SAMPLE_W-1:0]     gain_prop_q;
	logic [SAMPLE_W-1:0]     gain_deriv_q;
	logic [SAMPLE_W-1:0]     min_seen_q;
	logic [SAMPLE_W-1:0]     max_seen_q;
	logic [SAMPLE_W-1:0]     threshold_q;
	logic signed [ERR_W-1:0] last_error_q;

	logic [SAMPLE_W-1:0] smp [SENSOR_COUNT];
	lane_t               lanes [SENSOR_COUNT];
	status_t             st;

	logic advance;
	logic accept;
	logic is_cal;

	// stage 1: error and pattern
	logic                    v_s1;
	logic                    act_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic signed [ERR_W:0]   diff_s1;
	logic [PAT_W-1:0]        pat_s1;
	logic [SAMPLE_W-1:0]     thr_s1;

	// stage 2: products
	logic                    v_s2;
	logic                    act_s2;
	logic signed [ERR_W-1:0] err_s2;
	logic [PAT_W-1:0]        pat_s2;
	logic [SAMPLE_W-1:0]     thr_s2;
	logic signed [12:0]      prod_p_s2;
	logic signed [13:0]      prod_d_s2;

	logic signed [12:0] mul_p;
	logic signed [13:0] mul_d;
	logic signed [15:0] drive;
	logic signed [15:0] left_raw;
	logic signed [15:0] right_raw;
	logic [SAMPLE_W-1:0] left_sat;
	logic [SAMPLE_W-1:0] right_sat;

	result_t result_q;
	logic    res_valid_q;

	assign advance    = !res_valid_q || result_ready;
	assign item_ready = advance;
	assign accept     = item_valid && advance;
	assign is_cal     = (item.action == ACT_CALIBRATE);
	assign cfg_ready  = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= BASE_SPEED_RST;
			gain_prop_q  <= GAIN_PROP_RST;
			gain_deriv_q <= GAIN_DERIV_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE_SPEED: base_speed_q <= cfg_data;
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign smp[0] = item.sample_0;
	assign smp[1] = item.sample_1;
	assign smp[2] = item.sample_2;
	assign smp[3] = item.sample_3;
	assign smp[4] = item.sample_4;
	assign smp[5] = item.sample_5;

	for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
		lfpd_lane u_lane (
			.sample    (smp[g]),
			.threshold (threshold_q),
			.min_seen  (min_seen_q),
			.max_seen  (max_seen_q),
			.res       (lanes[g])
		);
	end

	lfpd_merge u_merge (
		.lanes      (lanes),
		.last_error (last_error_q),
		.st         (st)
	);

	// tracking state lives at the input so back-to-back items see it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_seen_q   <= MIN_SEEN_RST;
			max_seen_q   <= MAX_SEEN_RST;
			threshold_q  <= THRESHOLD_RST;
			last_error_q <= '0;
		end else if (accept) begin
			if (is_cal) begin
				min_seen_q  <= st.min_next;
				max_seen_q  <= st.max_next;
				threshold_q <= st.thr_cal;
			end else begin
				last_error_q <= st.err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= item.action;
			if (is_cal) begin
				err_s1  <= last_error_q;
				diff_s1 <= '0;
				pat_s1  <= '0;
				thr_s1  <= st.thr_cal;
			end else begin
				err_s1  <= st.err;
				diff_s1 <= st.diff;
				pat_s1  <= st.pattern;
				thr_s1  <= threshold_q;
			end
		end
	end

	assign mul_p = $signed({1'b0, gain_prop_q}) * err_s1;
	assign mul_d = $signed({1'b0, gain_deriv_q}) * diff_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			act_s2    <= act_s1;
			err_s2    <= err_s1;
			pat_s2    <= pat_s1;
			thr_s2    <= thr_s1;
			prod_p_s2 <= mul_p;
			prod_d_s2 <= mul_d;
		end
	end

	assign drive     = {{3{prod_p_s2[12]}}, prod_p_s2} + {{2{prod_d_s2[13]}}, prod_d_s2};
	assign left_raw  = $signed({8'b0, base_speed_q}) + drive;
	assign right_raw = $signed({8'b0, base_speed_q}) - drive;

	always_comb begin
		if (left_raw < 16'sd0)
			left_sat = '0;
		else if (left_raw > $signed({8'b0, DUTY_MAX}))
			left_sat = DUTY_MAX;
		else
			left_sat = left_raw[SAMPLE_W-1:0];
		if (right_raw < 16'sd0)
			right_sat = '0;
		else if (right_raw > $signed({8'b0, DUTY_MAX}))
			right_sat = DUTY_MAX;
		else
			right_sat = right_raw[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.left_duty      <= (act_s2 == ACT_STEER) ? left_sat : '0;
			result_q.right_duty     <= (act_s2 == ACT_STEER) ? right_sat : '0;
			result_q.position_error <= err_s2;
			result_q.sensor_pattern <= pat_s2;
			result_q.threshold_now  <= thr_s2;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lfpd_lane.sv -----
`default_nettype none
module lfpd_lane (
	input  wire logic [lfpd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [lfpd_pkg::SAMPLE_W-1:0] threshold,
	input  wire logic [lfpd_pkg::SAMPLE_W-1:0] min_seen,
	input  wire logic [lfpd_pkg::SAMPLE_W-1:0] max_seen,
	output lfpd_pkg::lane_t                    res
);
	import lfpd_pkg::*;

	always_comb begin
		res.above = (sample > threshold);
		res.lo    = (sample < min_seen) ? sample : min_seen;
		res.hi    = (sample > max_seen) ? sample : max_seen;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lfpd_merge.sv -----
`default_nettype none
module lfpd_merge (
	input  wire lfpd_pkg::lane_t                    lanes [lfpd_pkg::SENSOR_COUNT],
	input  wire logic signed [lfpd_pkg::ERR_W-1:0]  last_error,
	output lfpd_pkg::status_t                       st
);
	import lfpd_pkg::*;

	logic [SAMPLE_W-1:0]     lo;
	logic [SAMPLE_W-1:0]     hi;
	logic [SAMPLE_W-1:0]     span;
	logic [PAT_W-1:0]        pat;
	logic signed [ERR_W-1:0] err;

	always_comb begin
		lo = lanes[0].lo;
		hi = lanes[0].hi;
		for (int i = 1; i < SENSOR_COUNT; i++) begin
			if (lanes[i].lo < lo)
				lo = lanes[i].lo;
			if (lanes[i].hi > hi)
				hi = lanes[i].hi;
		end
		for (int i = 0; i < SENSOR_COUNT; i++)
			pat[PAT_W-1-i] = lanes[i].above;
	end

	assign span = hi - lo;
	assign err  = map_error(pat, last_error);

	always_comb begin
		st.pattern  = pat;
		st.err      = err;
		st.diff     = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
		st.min_next = lo;
		st.max_next = hi;
		st.thr_cal  = (hi >= lo) ? (lo + (span >> 1)) : lo;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lfpd_checker.sv -----
`default_nettype none
module lfpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire lfpd_pkg::result_t result
);
	import lfpd_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input blocked with no pending result");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.position_error >= -4'sd4))
		else $error("position error out of range");

	// line lost: error saturates to a side or stays centered
	a_all_white: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sensor_pattern == PAT_ALL_WHITE |->
		result.position_error == 4'sd4 || result.position_error == -4'sd4 ||
		result.position_error == 4'sd0)
		else $error("bad error for all-white pattern");

	a_center: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sensor_pattern == PAT_CENTER |->
		result.position_error == 4'sd0)
		else $error("centered pattern gave nonzero error");

endmodule

bind line_follower_pd_steering_unit lfpd_checker u_lfpd_checker (.*);
`default_nettype wire

// ----- tb/lfpd_steer_checker.sv -----
`timescale 1ns / 1ps
module lfpd_steer_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  logic                              item_ready,
	input  lfpd_pkg::item_t                   item,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  lfpd_pkg::result_t                 result,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpd_pkg::SAMPLE_W-1:0]     cfg_data,
	output int                                mismatches,
	output int                                outstanding
);
	import lfpd_pkg::*;

	logic [SAMPLE_W-1:0]     base_spd, kp, kd;
	logic [SAMPLE_W-1:0]     lo_seen, hi_seen, thr;
	logic signed [ERR_W-1:0] prev_err;
	result_t                 awaited [$];

	function automatic logic signed [ERR_W-1:0] error_of(
		input logic [PAT_W-1:0]        pat,
		input logic signed [ERR_W-1:0] prev
	);
		case (pat)
			PAT_CENTER:    return 4'sd0;
			PAT_LEFT_3:    return -4'sd3;
			PAT_LEFT_2:    return -4'sd2;
			PAT_LEFT_1:    return -4'sd1;
			PAT_RIGHT_1:   return 4'sd1;
			PAT_RIGHT_2:   return 4'sd2;
			PAT_RIGHT_3:   return 4'sd3;
			// line lost: saturate toward the side it left from
			PAT_ALL_WHITE: return (prev == 0) ? 4'sd0 : ((prev < 0) ? -4'sd4 : 4'sd4);
			default:       return prev;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] duty_clamp(input int v);
		if (v < 0)
			return '0;
		if (v > int'(DUTY_MAX))
			return DUTY_MAX;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic int field_diff(input string name, input int want_v, input int got_v);
		if (want_v == got_v)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
		return 1;
	endfunction

	// updates calibration and error history, then yields the result of this transfer
	task automatic predict_item(input item_t it, output result_t r);
		logic [SAMPLE_W-1:0]     smp [SENSOR_COUNT];
		logic [PAT_W-1:0]        pat;
		logic signed [ERR_W-1:0] err;
		int                      e_now, e_old, gp_i, gd_i, drive;
		smp = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3, it.sample_4, it.sample_5};
		r = '0;
		if (it.action == ACT_CALIBRATE) begin
			foreach (smp[k]) begin
				if (smp[k] < lo_seen)
					lo_seen = smp[k];
				if (smp[k] > hi_seen)
					hi_seen = smp[k];
			end
			thr = (hi_seen >= lo_seen) ? lo_seen + ((hi_seen - lo_seen) >> 1) : lo_seen;
			r.position_error = prev_err;
			r.threshold_now  = thr;
		end else begin
			pat = '0;
			foreach (smp[k])
				pat[PAT_W-1-k] = (smp[k] > thr);
			err   = error_of(pat, prev_err);
			e_now = err;
			e_old = prev_err;
			gp_i  = kp;
			gd_i  = kd;
			drive = gp_i * e_now + gd_i * (e_now - e_old);
			prev_err = err;
			r.left_duty      = duty_clamp(int'(base_spd) + drive);
			r.right_duty     = duty_clamp(int'(base_spd) - drive);
			r.position_error = err;
			r.sensor_pattern = pat;
			r.threshold_now  = thr;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want, fresh;
		if (!arst_n) begin
			base_spd   = BASE_SPEED_RST;
			kp         = GAIN_PROP_RST;
			kd         = GAIN_DERIV_RST;
			lo_seen    = MIN_SEEN_RST;
			hi_seen    = MAX_SEEN_RST;
			thr        = THRESHOLD_RST;
			prev_err   = '0;
			mismatches = 0;
			awaited.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_SPEED: base_spd = cfg_data;
					REG_GAIN_PROP:  kp = cfg_data;
					REG_GAIN_DERIV: kd = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited.size() == 0) begin
					$display("%0t: result transfer expected none, got %p", $time, result);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					mismatches += field_diff("left_duty", want.left_duty, result.left_duty);
					mismatches += field_diff("right_duty", want.right_duty, result.right_duty);
					mismatches += field_diff("position_error",
						$signed(want.position_error), $signed(result.position_error));
					mismatches += field_diff("sensor_pattern",
						want.sensor_pattern, result.sensor_pattern);
					mismatches += field_diff("threshold_now",
						want.threshold_now, result.threshold_now);
				end
			end
			if (item_valid && item_ready) begin
				predict_item(item, fresh);
				awaited.push_back(fresh);
			end
		end
		outstanding = awaited.size();
	end

endmodule

// ----- tb/tb_line_follower_pd_steering_unit.sv -----
`timescale 1ns / 1ps
module tb_line_follower_pd_steering_unit;
	import lfpd_pkg::*;

	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam logic [PAT_W-1:0]     PAT_ALL_DARK = 6'b000000;
	localparam logic [PAT_W-1:0]     PAT_STRIPED  = 6'b101010;
	localparam int                   PHASE_ITEMS  = 175;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_ready;
	item_t                  item;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [SAMPLE_W-1:0]    cfg_data;
	int                     mismatches;
	int                     outstanding;

	int                     burst_left = 0;
	bit                     gaps_on = 1'b1;
	int                     rx_cycle = 0;
	int                     hold_left = 0;
	rx_mode_e               rx_mode = RX_OPEN;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	line_follower_pd_steering_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lfpd_steer_checker i_checker (.*);

	// white sensors land above the threshold, dark ones at or below it
	function automatic item_t make_steer(
		input logic [PAT_W-1:0]    pat,
		input logic [SAMPLE_W-1:0] white,
		input logic [SAMPLE_W-1:0] dark,
		input bit                  spread
	);
		logic [SAMPLE_W-1:0] v [SENSOR_COUNT];
		foreach (v[k]) begin
			if (pat[PAT_W-1-k])
				v[k] = spread ? SAMPLE_W'($urandom_range(white, 255)) : white;
			else
				v[k] = spread ? SAMPLE_W'($urandom_range(0, dark)) : dark;
		end
		return '{ACT_STEER, v[0], v[1], v[2], v[3], v[4], v[5]};
	endfunction

	// threshold sits at 127 once calibration has seen both 0 and 255
	function automatic item_t random_item();
		item_t            it;
		logic [PAT_W-1:0] pat;
		int               roll;
		roll = $urandom_range(0, 99);
		it = '{ACT_STEER, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom)};
		if (roll < 6) begin
			it.action = ACT_CALIBRATE;
		end else if (roll >= 16) begin
			case ($urandom_range(0, 7))
				0: pat = PAT_CENTER;
				1: pat = PAT_LEFT_3;
				2: pat = PAT_LEFT_2;
				3: pat = PAT_LEFT_1;
				4: pat = PAT_RIGHT_1;
				5: pat = PAT_RIGHT_2;
				6: pat = PAT_RIGHT_3;
				default: pat = PAT_ALL_WHITE;
			endcase
			if ($urandom_range(0, 3) == 0)
				it = make_steer(pat, 8'd128, 8'd127, 1'b0);
			else
				it = make_steer(pat, 8'd128, 8'd127, 1'b1);
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if (gaps_on && burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic program_regs(
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] p,
		input logic [SAMPLE_W-1:0] d,
		input bit                  poke_unused
	);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [SAMPLE_W-1:0]  val [4];
		int                   n;
		idx[0] = REG_BASE_SPEED;
		val[0] = b;
		idx[1] = REG_GAIN_PROP;
		val[1] = p;
		idx[2] = REG_GAIN_DERIV;
		val[2] = d;
		idx[3] = REG_UNUSED;
		val[3] = 8'($urandom);
		n = poke_unused ? 4 : 3;
		cfg_valid <= 1'b1;
		for (int k = 0; k < n; k++) begin
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// result side: rotating stall patterns plus a periodic long hold-off
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		if (rx_cycle % 1500 == 300)
			hold_left = 60;
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   result_ready <= 1'b1;
				RX_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
				RX_MOSTLY: result_ready <= ($urandom_range(0, 7) != 0);
				default:   result_ready <= ((rx_cycle % 5) < 2);
			endcase
		end
	end

	initial begin : stimulus
		logic [SAMPLE_W-1:0] plan_base [6];
		logic [SAMPLE_W-1:0] plan_kp [6];
		logic [SAMPLE_W-1:0] plan_kd [6];
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		plan_base = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom_range(60, 200)), 8'($urandom)};
		plan_kp   = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom_range(0, 31)), 8'($urandom)};
		plan_kd   = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom_range(0, 31)), 8'($urandom)};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset gains, threshold still 128
		send_item(make_steer(PAT_ALL_DARK, 8'd0, 8'd128, 1'b0));
		send_item(make_steer(PAT_ALL_WHITE, 8'd129, 8'd128, 1'b0));
		send_item(make_steer(PAT_RIGHT_1, 8'd129, 8'd128, 1'b0));
		send_item(make_steer(PAT_ALL_WHITE, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_STRIPED, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_LEFT_3, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_ALL_WHITE, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_CENTER, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_LEFT_2, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_LEFT_1, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_RIGHT_2, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_RIGHT_3, 8'd255, 8'd0, 1'b0));
		send_item(make_steer(PAT_ALL_DARK, 8'd255, 8'd0, 1'b0));
		// calibration: degenerate all-255 range pins threshold at 255
		send_item('{ACT_CALIBRATE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
		send_item(make_steer(PAT_ALL_WHITE, 8'd255, 8'd0, 1'b0));
		send_item('{ACT_CALIBRATE, 8'd100, 8'd110, 8'd200, 8'd255, 8'd150, 8'd101});
		send_item(make_steer(PAT_RIGHT_3, 8'd178, 8'd177, 1'b0));
		send_item('{ACT_CALIBRATE, 8'd37, 8'd0, 8'd255, 8'd12, 8'd99, 8'd255});
		send_item(make_steer(PAT_LEFT_2, 8'd128, 8'd127, 1'b0));
		send_item(make_steer(PAT_ALL_WHITE, 8'd255, 8'd255, 1'b0));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			program_regs(plan_base[ph], plan_kp[ph], plan_kd[ph], ph == 3);
			// one phase streams back to back to keep the pipe full
			gaps_on = (ph != 2);
			burst_left = 0;
			repeat (PHASE_ITEMS)
				send_item(random_item());
			drain();
		end

		repeat (12) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** line_follower_pd_steering_unit: PASSED **");
		else
			$display("** line_follower_pd_steering_unit: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("** line_follower_pd_steering_unit: FAILED **");
		$finish;
	end

endmodule
